[hdl/sps_pkg.sv]
`timescale 1ns / 1ps

package sps_pkg;

    localparam int COILS_W      = 4;
    localparam int CFG_DATA_W   = 4;
    localparam int COUNT_W      = 16;
    localparam int DELAY_W      = 16;
    localparam int PATTERN_W    = 8;
    localparam int PHASE_IDX_W  = 4;
    // wide enough for the longest sequence (2 * 15 phases) plus one
    localparam int WORK_W       = 6;

    typedef enum logic [1:0] {
        MODE_WAVE = 2'd0,
        MODE_FULL = 2'd1,
        MODE_HALF = 2'd2,
        MODE_OFF  = 2'd3
    } drive_mode_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } op_t;

    typedef enum logic {
        REG_COILS_USED = 1'b0,
        REG_DRIVE_MODE = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [COUNT_W-1:0] steps_left;
        logic [DELAY_W-1:0] wait_left;
        logic [DELAY_W-1:0] wait_reload;
        logic               reverse_dir;
    } move_t;

    typedef struct packed {
        logic [PHASE_IDX_W-1:0] phase_index;
        logic                   moving;
        logic                   stepped;
        logic [PATTERN_W-1:0]   coil_pattern;
    } result_t;

endpackage

[hdl/sps_step.sv]
`timescale 1ns / 1ps

module sps_step #(
    parameter int MAX_COILS = 8,
    parameter int PW        = 4
) (
    input  logic [sps_pkg::COILS_W-1:0]      coils_used,
    input  sps_pkg::drive_mode_t             drive_mode,
    input  sps_pkg::op_t                     op,
    input  logic [sps_pkg::COUNT_W-1:0]      move_steps,
    input  logic [sps_pkg::DELAY_W-1:0]      delay_ticks,
    input  logic [PW-1:0]                    pos,
    input  sps_pkg::move_t                   move,
    output logic [PW-1:0]                    pos_next,
    output sps_pkg::move_t                   move_next,
    output logic [sps_pkg::WORK_W-1:0]       pos_next_w,
    output logic [sps_pkg::WORK_W-1:0]       seq_len,
    output logic                             stepped,
    output logic                             moving
);

    logic [sps_pkg::WORK_W-1:0]  n_w;
    logic [sps_pkg::WORK_W-1:0]  pos_w;
    logic [sps_pkg::WORK_W-1:0]  base;
    logic [sps_pkg::WORK_W-1:0]  fwd_pos;
    logic [sps_pkg::WORK_W-1:0]  rev_pos;
    logic [sps_pkg::COUNT_W-1:0] magnitude;
    logic                        neg;

    assign n_w   = sps_pkg::WORK_W'(coils_used);
    assign pos_w = sps_pkg::WORK_W'(pos);

    always_comb
    begin
        seq_len = '0;
        if (n_w != '0 && n_w <= sps_pkg::WORK_W'(MAX_COILS))
        begin
            case (drive_mode)
                sps_pkg::MODE_WAVE, sps_pkg::MODE_FULL: seq_len = n_w;
                sps_pkg::MODE_HALF: seq_len = {n_w[sps_pkg::WORK_W-2:0], 1'b0};
                default:            seq_len = '0;
            endcase
        end
    end

    // neighbor phases with wraparound
    assign base    = (pos_w >= seq_len) ? '0 : pos_w;
    assign fwd_pos = (base + 1'b1 >= seq_len) ? '0 : base + 1'b1;
    assign rev_pos = (base == '0) ? seq_len - 1'b1 : base - 1'b1;

    assign neg       = move_steps[sps_pkg::COUNT_W-1];
    assign magnitude = neg ? sps_pkg::COUNT_W'(~move_steps + 1'b1) : move_steps;

    always_comb
    begin
        move_next  = move;
        pos_next_w = pos_w;
        stepped    = 1'b0;
        if (seq_len == '0)
        begin
            move_next.steps_left = '0;
            move_next.wait_left  = '0;
        end
        else if (op == sps_pkg::OP_START)
        begin
            move_next.reverse_dir = neg;
            move_next.wait_reload = delay_ticks;
            move_next.wait_left   = '0;
            move_next.steps_left  = magnitude;
            if (magnitude != '0)
            begin
                pos_next_w           = neg ? rev_pos : fwd_pos;
                move_next.steps_left = magnitude - 1'b1;
                move_next.wait_left  = delay_ticks;
                stepped              = 1'b1;
            end
        end
        else if (move.wait_left != '0)
        begin
            move_next.wait_left = move.wait_left - 1'b1;
        end
        else if (move.steps_left != '0)
        begin
            pos_next_w           = move.reverse_dir ? rev_pos : fwd_pos;
            move_next.steps_left = move.steps_left - 1'b1;
            move_next.wait_left  = move.wait_reload;
            stepped              = 1'b1;
        end
    end

    assign pos_next = pos_next_w[PW-1:0];
    assign moving   = (move_next.steps_left != '0) || (move_next.wait_left != '0);

endmodule

[hdl/sps_pattern.sv]
`timescale 1ns / 1ps

module sps_pattern (
    input  logic [sps_pkg::COILS_W-1:0]      coils_used,
    input  sps_pkg::drive_mode_t             drive_mode,
    input  logic [sps_pkg::WORK_W-1:0]       phase,
    input  logic [sps_pkg::WORK_W-1:0]       seq_len,
    output logic [sps_pkg::PATTERN_W-1:0]    coil_pattern
);

    logic [sps_pkg::WORK_W-1:0] n_w;
    logic [sps_pkg::WORK_W-1:0] first_coil;
    logic [sps_pkg::WORK_W-1:0] second_coil;
    logic                       two_coils;
    logic                       active;

    assign n_w    = sps_pkg::WORK_W'(coils_used);
    assign active = (seq_len != '0) && (phase < seq_len);

    always_comb
    begin
        first_coil = phase;
        two_coils  = 1'b0;
        case (drive_mode)
            sps_pkg::MODE_WAVE:
            begin
                first_coil = phase;
                two_coils  = 1'b0;
            end
            sps_pkg::MODE_FULL:
            begin
                first_coil = phase;
                two_coils  = 1'b1;
            end
            default:
            begin
                first_coil = phase >> 1;
                two_coils  = phase[0];
            end
        endcase
    end

    assign second_coil = (first_coil + 1'b1 == n_w) ? '0 : first_coil + 1'b1;

    always_comb
    begin
        for (int c = 0; c < sps_pkg::PATTERN_W; c++)
        begin
            coil_pattern[c] = active &&
                ((first_coil == sps_pkg::WORK_W'(c)) ||
                 (two_coils && second_coil == sps_pkg::WORK_W'(c)));
        end
    end

endmodule

[hdl/stepper_phase_sequencer_core.sv]
`timescale 1ns / 1ps

// stepper phase sequencer: drives up to MAX_COILS coils in wave, full or half step
// input stream (s_*): one beat per time tick or move start; tuser carries op
//   (0 tick, 1 start), tdata carries the signed step count and delay_ticks
// output stream (m_*): exactly one result beat per input beat, in order, with the
//   coil pattern, stepped and moving flags and the phase index after that beat
// config port: cfg_we writes coils_used (index 0) or drive_mode (index 1); any write
//   clears the phase index, writes are expected only while the block is idle
// result: registered, so it appears in the cycle after its input beat is accepted
// throughput: one beat per cycle while results are taken; the phase update and
//   pattern decode sit combinationally between the state and output registers
// stall: s_tready is high whenever the output register is empty or being taken, so
//   a stalled receiver holds the current result and blocks only new input beats
// reset: 4 coils, full step mode, phase 0, no move in progress, output empty
module stepper_phase_sequencer_core #(
    parameter int MAX_COILS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // move_steps[15:0], delay_ticks[31:16]
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // coil_pattern[7:0], stepped[8], moving[9],
                                   // phase_index[13:10], zero[15:14]
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int PW = (MAX_COILS > 1) ? $clog2(2 * MAX_COILS) : 1;

    logic [sps_pkg::COILS_W-1:0]      coils_used_reg;
    sps_pkg::drive_mode_t             drive_mode_reg;
    logic [PW-1:0]                    pos_reg;
    logic [PW-1:0]                    pos_next;
    sps_pkg::move_t                   move_reg;
    sps_pkg::move_t                   move_next;
    sps_pkg::result_t                 result_reg;
    sps_pkg::result_t                 result_next;
    logic                             out_valid_reg;

    logic [sps_pkg::WORK_W-1:0]       pos_next_w;
    logic [sps_pkg::WORK_W-1:0]       seq_len;
    logic                             stepped;
    logic                             moving;
    logic [sps_pkg::PATTERN_W-1:0]    coil_pattern;
    logic                             in_accept;

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    sps_step #(
        .MAX_COILS (MAX_COILS),
        .PW        (PW)
    ) u_step (
        .coils_used  (coils_used_reg),
        .drive_mode  (drive_mode_reg),
        .op          (sps_pkg::op_t'(s_tuser)),
        .move_steps  (s_tdata[15:0]),
        .delay_ticks (s_tdata[31:16]),
        .pos         (pos_reg),
        .move        (move_reg),
        .pos_next    (pos_next),
        .move_next   (move_next),
        .pos_next_w  (pos_next_w),
        .seq_len     (seq_len),
        .stepped     (stepped),
        .moving      (moving)
    );

    sps_pattern u_pattern (
        .coils_used   (coils_used_reg),
        .drive_mode   (drive_mode_reg),
        .phase        (pos_next_w),
        .seq_len      (seq_len),
        .coil_pattern (coil_pattern)
    );

    always_comb
    begin
        result_next.coil_pattern = coil_pattern;
        result_next.stepped      = stepped;
        result_next.moving       = moving;
        result_next.phase_index  = pos_next_w[sps_pkg::PHASE_IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coils_used_reg <= sps_pkg::COILS_W'(4);
            drive_mode_reg <= sps_pkg::MODE_FULL;
            pos_reg        <= '0;
            move_reg       <= '0;
        end
        else if (cfg_we)
        begin
            pos_reg <= '0;
            unique case (sps_pkg::reg_index_t'(cfg_index))
                sps_pkg::REG_COILS_USED: coils_used_reg <= cfg_data;
                sps_pkg::REG_DRIVE_MODE: drive_mode_reg <= sps_pkg::drive_mode_t'(cfg_data[1:0]);
            endcase
        end
        else if (in_accept)
        begin
            pos_reg  <= pos_next;
            move_reg <= move_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, result_reg};

endmodule

[hdl/sps_checker.sv]
`timescale 1ns / 1ps

module sps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // every accepted input beat yields a result beat next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted beat gave no result");

    // empty output register never blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // no result invented without an input beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) && !s_tvalid |=> !m_tvalid)
        else $error("result beat without input beat");

endmodule

bind stepper_phase_sequencer_core sps_checker u_sps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
